// File: hw/rtl/afc_pkg.sv
package afc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int PlaneIdxW  = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

  localparam int CoefW  = 16;
  localparam int ProdW  = 2 * CoefW;
  localparam int DShift = 12;
  localparam int AccW   = ProdW + 2;

  typedef struct packed {
    logic signed [CoefW-1:0] a;
    logic signed [CoefW-1:0] b;
    logic signed [CoefW-1:0] c;
    logic signed [CoefW-1:0] d;
  } plane_t;

  typedef struct packed {
    logic start;
    logic accum;
  } mac_ctrl_t;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TEST = 1'b1;

endpackage

// File: hw/rtl/afc_mac.sv
module afc_mac import afc_pkg::*; (
  input  logic                    clk_i,
  input  mac_ctrl_t               ctrl_i,
  input  logic signed [CoefW-1:0] coef_i,
  input  logic signed [CoefW-1:0] lo_i,
  input  logic signed [CoefW-1:0] hi_i,
  input  logic signed [CoefW-1:0] offset_i,
  output logic                    le_zero_o
);

  logic signed [CoefW-1:0] sel;
  logic signed [ProdW-1:0] prod_d, prod_q;
  logic signed [AccW-1:0]  acc_d, acc_q, sum;

  // larger of coef*lo and coef*hi picks the corner by the sign of coef
  always_comb begin
    if (coef_i >= 0) begin
      sel = (lo_i > hi_i) ? lo_i : hi_i;
    end else begin
      sel = (lo_i < hi_i) ? lo_i : hi_i;
    end
  end

  assign prod_d = coef_i * sel;
  assign sum    = acc_q + AccW'(prod_q);

  always_comb begin
    priority if (ctrl_i.start) begin
      acc_d = {{(AccW - CoefW - DShift){offset_i[CoefW-1]}}, offset_i, {DShift{1'b0}}};
    end else if (ctrl_i.accum) begin
      acc_d = sum;
    end else begin
      acc_d = acc_q;
    end
  end

  assign le_zero_o = sum[AccW-1] || (sum == '0);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

endmodule

// File: hw/rtl/aabb_frustum_cull.sv
// box against frustum culling with a store of clipping planes
// input channel: in_valid_i / in_stall_o carry one word per item
//   kind_i = load: coef_a_i..coef_d_i go to slot plane_index_i, no result;
//   a slot index beyond the store is dropped
//   kind_i = test: box_min_* / box_max_* give the box, one result follows
// output channel: out_valid_o / out_stall_i carry box_visible_o
//   (1 = visible, 0 = culled behind some plane)
// a test runs plane by plane through one shared multiply-accumulate unit,
// in four steps per plane (three products and the final add and compare),
// stopping at the first plane that culls the box
// a test examines from 1 to 6 planes
// in_stall_o is high while a test is in flight; else loads stream at one per cycle
// reset clears all planes to zero, so every box is culled until planes are
// loaded, and drops any pending result
// a stalled result waits in the output register; the next test may be
// accepted meanwhile but does not finish until that register frees up
module aabb_frustum_cull import afc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              kind_i,
  input  logic [2:0]        plane_index_i,
  input  logic signed [15:0] coef_a_i,
  input  logic signed [15:0] coef_b_i,
  input  logic signed [15:0] coef_c_i,
  input  logic signed [15:0] coef_d_i,
  input  logic signed [15:0] box_min_x_i,
  input  logic signed [15:0] box_min_y_i,
  input  logic signed [15:0] box_min_z_i,
  input  logic signed [15:0] box_max_x_i,
  input  logic signed [15:0] box_max_y_i,
  input  logic signed [15:0] box_max_z_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              box_visible_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    STEP_X,
    STEP_Y,
    STEP_Z,
    STEP_CHK
  } step_e;

  state_e                 state_q, state_d;
  step_e                  step_q, step_d;
  logic [PlaneIdxW-1:0]   plane_q, plane_d;
  logic                   res_q, res_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_vis_q, out_vis_d;

  plane_t                 store_q [NUM_PLANES];
  logic signed [CoefW-1:0] mnx_q, mny_q, mnz_q, mxx_q, mxy_q, mxz_q;

  logic                   accept;
  logic                   load_we;
  logic                   test_go;
  plane_t                 cur;
  mac_ctrl_t              ctrl;
  logic signed [CoefW-1:0] coef, lo, hi;
  logic                   le_zero;

  assign in_stall_o    = (state_q != ST_IDLE);
  assign accept        = in_valid_i && !in_stall_o;
  assign load_we       = accept && (kind_i == KIND_LOAD) &&
                         ({1'b0, plane_index_i} < 4'(NUM_PLANES));
  assign test_go       = accept && (kind_i == KIND_TEST);
  assign out_valid_o   = out_valid_q;
  assign box_visible_o = out_vis_q;
  assign cur           = store_q[plane_q];

  // operand select for the shared unit
  always_comb begin
    ctrl = '0;
    coef = cur.a;
    lo   = mnx_q;
    hi   = mxx_q;
    unique case (step_q)
      STEP_X: begin
        ctrl.start = (state_q == ST_RUN);
      end
      STEP_Y: begin
        coef       = cur.b;
        lo         = mny_q;
        hi         = mxy_q;
        ctrl.accum = (state_q == ST_RUN);
      end
      STEP_Z: begin
        coef       = cur.c;
        lo         = mnz_q;
        hi         = mxz_q;
        ctrl.accum = (state_q == ST_RUN);
      end
      STEP_CHK: begin
      end
      default: begin
      end
    endcase
  end

  afc_mac u_mac (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .coef_i    (coef),
    .lo_i      (lo),
    .hi_i      (hi),
    .offset_i  (cur.d),
    .le_zero_o (le_zero)
  );

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    plane_d     = plane_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_vis_d   = out_vis_q;
    unique case (state_q)
      ST_IDLE: begin
        if (test_go) begin
          state_d = ST_RUN;
          step_d  = STEP_X;
          plane_d = '0;
        end
      end
      ST_RUN: begin
        unique case (step_q)
          STEP_X:   step_d = STEP_Y;
          STEP_Y:   step_d = STEP_Z;
          STEP_Z:   step_d = STEP_CHK;
          STEP_CHK: begin
            step_d = STEP_X;
            if (le_zero) begin
              res_d   = 1'b0;
              state_d = ST_DONE;
            end else if (plane_q == PlaneIdxW'(NUM_PLANES - 1)) begin
              res_d   = 1'b1;
              state_d = ST_DONE;
            end else begin
              plane_d = plane_q + 1'b1;
            end
          end
          default:  step_d = STEP_X;
        endcase
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_vis_d   = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_X;
      plane_q     <= '0;
      res_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_vis_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      plane_q     <= plane_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_vis_q   <= out_vis_d;
    end
  end

  // plane store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        store_q[i] <= '0;
      end
    end else if (load_we) begin
      store_q[plane_index_i[PlaneIdxW-1:0]] <= '{a: coef_a_i, b: coef_b_i,
                                                 c: coef_c_i, d: coef_d_i};
    end
  end

  // box word
  always_ff @(posedge clk_i) begin
    if (test_go) begin
      mnx_q <= box_min_x_i;
      mny_q <= box_min_y_i;
      mnz_q <= box_min_z_i;
      mxx_q <= box_max_x_i;
      mxy_q <= box_max_y_i;
      mxz_q <= box_max_z_i;
    end
  end

`ifndef SYNTHESIS
  a_test_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    test_go |=> in_stall_o)
    else $error("test word did not make the block busy");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i == KIND_LOAD) |=> !in_stall_o)
    else $error("load word left the block busy");

  a_plane_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> ({1'b0, plane_q} < (PlaneIdxW + 1)'(NUM_PLANES)))
    else $error("plane counter out of range");

  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !(out_valid_q && out_stall_i))
      |=> (out_valid_o && box_visible_o == $past(res_q)))
    else $error("finished result not presented");
`endif

endmodule
